[hdl/wgm_pkg.sv]
`default_nettype none
package wgm_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int NAME_DEPTH    = 256;

  localparam int PAT_AW  = $clog2(PATTERN_DEPTH);
  localparam int PAT_LW  = $clog2(PATTERN_DEPTH + 1);
  localparam int NAME_AW = $clog2(NAME_DEPTH);
  localparam int NAME_LW = $clog2(NAME_DEPTH + 1);

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_NAME    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MFETCH,
    ST_MEVAL,
    ST_TFETCH,
    ST_TEVAL,
    ST_DONE
  } wgm_state_t;

  // store write port, driven by the loader
  typedef struct packed {
    logic               pat_we;
    logic [PAT_AW-1:0]  pat_addr;
    logic               name_we;
    logic [NAME_AW-1:0] name_addr;
    logic [7:0]         data;
  } wgm_wr_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic matched;
  } wgm_stat_t;

endpackage
`default_nettype wire

[hdl/wgm_in_if.sv]
`default_nettype none
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, op, ch, has_char, last, input ready);
  modport sink   (input valid, op, ch, has_char, last, output ready);
endinterface
`default_nettype wire

[hdl/wgm_out_if.sv]
`default_nettype none
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic too_long;

  modport source (output valid, matched, too_long, input ready);
  modport sink   (input valid, matched, too_long, output ready);
endinterface
`default_nettype wire

[hdl/wgm_walk.sv]
`default_nettype none
module wgm_walk (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire wgm_pkg::wgm_wr_t            wr,
  input  wire logic                        start,
  input  wire logic                        lng,
  input  wire logic [wgm_pkg::PAT_LW-1:0]  pattern_length,
  input  wire logic [wgm_pkg::NAME_LW-1:0] name_length,
  input  wire logic                        ack,
  output wgm_pkg::wgm_stat_t               stat
);
  import wgm_pkg::*;

  logic [7:0] pat_mem  [PATTERN_DEPTH];
  logic [7:0] name_mem [NAME_DEPTH];
  logic [7:0] pat_rd;
  logic [7:0] name_rd;

  wgm_state_t         state, state_next;
  logic [PAT_LW-1:0]  pattern_pos;
  logic [NAME_LW-1:0] name_pos;
  logic [PAT_LW-1:0]  star_pos;
  logic               star_valid;
  logic [NAME_LW-1:0] resume_pos;
  logic               matched;

  logic in_pat, is_star, hit, fail;

  // stores: one write, one registered read each
  always_ff @(posedge clk) begin
    if (wr.pat_we) begin
      pat_mem[wr.pat_addr] <= wr.data;
    end
    if (wr.name_we) begin
      name_mem[wr.name_addr] <= wr.data;
    end
    pat_rd  <= pat_mem[pattern_pos[PAT_AW-1:0]];
    name_rd <= name_mem[name_pos[NAME_AW-1:0]];
  end

  assign in_pat  = pattern_pos < pattern_length;
  assign is_star = pat_rd == STAR_BYTE;
  assign hit     = in_pat && !is_star && (pat_rd == name_rd || pat_rd == ANY_BYTE);
  assign fail    = !(in_pat && is_star) && !hit && !star_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = lng ? ST_DONE : ST_MFETCH;
      ST_MFETCH: state_next = (name_pos < name_length) ? ST_MEVAL : ST_TFETCH;
      ST_MEVAL:  state_next = fail ? ST_DONE : ST_MFETCH;
      ST_TFETCH: state_next = in_pat ? ST_TEVAL : ST_DONE;
      ST_TEVAL:  state_next = is_star ? ST_TFETCH : ST_DONE;
      ST_DONE:   if (ack) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.idle    = state == ST_IDLE;
    stat.done    = state == ST_DONE;
    stat.matched = matched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pattern_pos <= '0;
      name_pos    <= '0;
      star_pos    <= '0;
      star_valid  <= 1'b0;
      resume_pos  <= '0;
      matched     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            pattern_pos <= '0;
            name_pos    <= '0;
            star_pos    <= '0;
            star_valid  <= 1'b0;
            resume_pos  <= '0;
            matched     <= 1'b0;
          end
        end
        ST_MEVAL: begin
          if (in_pat && is_star) begin
            star_valid  <= 1'b1;
            star_pos    <= pattern_pos;
            pattern_pos <= PAT_LW'(pattern_pos + 1'b1);
            resume_pos  <= name_pos;
          end else if (hit) begin
            pattern_pos <= PAT_LW'(pattern_pos + 1'b1);
            name_pos    <= NAME_LW'(name_pos + 1'b1);
          end else if (star_valid) begin
            // back up to just past the last star, one name byte later
            pattern_pos <= PAT_LW'(star_pos + 1'b1);
            resume_pos  <= NAME_LW'(resume_pos + 1'b1);
            name_pos    <= NAME_LW'(resume_pos + 1'b1);
          end else begin
            matched <= 1'b0;
          end
        end
        ST_TFETCH: begin
          if (!in_pat) matched <= 1'b1;
        end
        ST_TEVAL: begin
          if (is_star) pattern_pos <= PAT_LW'(pattern_pos + 1'b1);
          else matched <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_pat_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE && state != ST_DONE |-> pattern_pos <= pattern_length)
    else $error("pattern position past pattern length");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE && state != ST_DONE |-> name_pos <= name_length)
    else $error("name position past name length");

  a_star_behind: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE && star_valid |-> star_pos < pattern_pos && resume_pos <= name_pos)
    else $error("saved star point ahead of walk");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("walk started while busy");

  a_lng_nomatch: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && start && lng |=> state == ST_DONE && !matched)
    else $error("overflowed item did not finish unmatched");

endmodule
`default_nettype wire

[hdl/wildcard_glob_matcher.sv]
// Pattern and name bytes go to their stores as they are taken. After the last name
// byte the walk runs in steps, each a store read and then a compare; steps grow up to
// about pattern_length * name_length, plus one per trailing star.
// Throughput: one load transaction per cycle; none until a walk result is registered.
// Reset clears lengths, overflow flags, walker and output valid; stores are not cleared.
`default_nettype none
module wildcard_glob_matcher (
  input wire logic  clk,
  input wire logic  rst,
  wgm_in_if.sink    in_ch,
  wgm_out_if.source out_ch
);
  import wgm_pkg::*;

  logic [PAT_LW-1:0]  pattern_length;
  logic [NAME_LW-1:0] name_length;
  logic               pattern_open;
  logic               pattern_overflow;
  logic               overflow_seen;
  logic               out_valid;
  logic               out_matched;
  logic               out_too_long;

  logic               take;
  logic               ack;
  logic [PAT_LW-1:0]  plen_base;
  logic               povf_base;
  logic               pat_room;
  logic               name_room;
  logic               name_ovf_next;
  logic               start;
  wgm_wr_t            wr;
  wgm_stat_t          stat;

  assign in_ch.ready = stat.idle;
  assign take        = in_ch.valid && in_ch.ready;
  assign ack         = stat.done && (!out_valid || out_ch.ready);

  // a pattern byte with no pattern open starts a fresh pattern
  assign plen_base     = pattern_open ? pattern_length : '0;
  assign povf_base     = pattern_open ? pattern_overflow : 1'b0;
  assign pat_room      = plen_base < PAT_LW'(PATTERN_DEPTH);
  assign name_room     = name_length < NAME_LW'(NAME_DEPTH);
  assign name_ovf_next = overflow_seen || (in_ch.has_char && !name_room);
  assign start         = take && in_ch.op == OP_NAME && in_ch.last;

  always_comb begin
    wr.data      = in_ch.ch;
    wr.pat_addr  = plen_base[PAT_AW-1:0];
    wr.name_addr = name_length[NAME_AW-1:0];
    wr.pat_we    = take && in_ch.op == OP_PATTERN && in_ch.has_char && pat_room;
    wr.name_we   = take && in_ch.op == OP_NAME && in_ch.has_char && name_room;
  end

  wgm_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .start          (start),
    .lng            (name_ovf_next || pattern_overflow),
    .pattern_length (pattern_length),
    .name_length    (name_length),
    .ack            (ack),
    .stat           (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      name_length      <= '0;
      pattern_open     <= 1'b0;
      pattern_overflow <= 1'b0;
      overflow_seen    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (take) begin
        if (in_ch.op == OP_PATTERN) begin
          pattern_open <= !in_ch.last;
          if (in_ch.has_char && pat_room) begin
            pattern_length <= PAT_LW'(plen_base + 1'b1);
          end else begin
            pattern_length <= plen_base;
          end
          if (in_ch.has_char && !pat_room) begin
            pattern_overflow <= 1'b1;
          end else begin
            pattern_overflow <= povf_base;
          end
        end else begin
          pattern_open  <= 1'b0;
          overflow_seen <= name_ovf_next;
          if (in_ch.has_char && name_room) begin
            name_length <= NAME_LW'(name_length + 1'b1);
          end
        end
      end
      if (ack) begin
        out_valid     <= 1'b1;
        name_length   <= '0;
        overflow_seen <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_matched  <= stat.matched;
      out_too_long <= overflow_seen || pattern_overflow;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.matched  = out_matched;
  assign out_ch.too_long = out_too_long;

  a_ready_walk: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ch.ready)
    else $error("input ready during walk");

  a_too_long_nomatch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_matched && out_too_long))
    else $error("match reported with overflow");

  a_name_cleared: assert property (@(posedge clk) disable iff (rst)
    ack |=> name_length == '0 && !overflow_seen)
    else $error("name state not cleared after result");

endmodule
`default_nettype wire
